// ----- rtl/core/psks_pkg.sv -----
// ----------------------------------------------------------------------------
// psks_pkg: shared types for the sorted key substitution block
// Field widths, opcodes and status codes used by the channels and the core.
// ----------------------------------------------------------------------------
package psks_pkg;

  localparam int OPCODE_W = 2;
  localparam int SEL_W    = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FINISH = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_LOADED = 2'd2
  } status_t;

endpackage

// ----- rtl/core/psks_in_if.sv -----
// ----------------------------------------------------------------------------
// psks_in_if: request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface psks_in_if;
  import psks_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SEL_W-1:0]    table_sel;
  logic [KEY_W-1:0]    from_key;
  logic [KEY_W-1:0]    to_key;

  modport source (output valid, output opcode, output table_sel, output from_key,
                  output to_key, input ready);
  modport sink   (input valid, input opcode, input table_sel, input from_key,
                  input to_key, output ready);
endinterface

// ----- rtl/core/psks_out_if.sv -----
// ----------------------------------------------------------------------------
// psks_out_if: result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface psks_out_if;
  import psks_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [KEY_W-1:0]    result_key;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output found, output result_key, output status,
                  input ready);
  modport sink   (input valid, input found, input result_key, input status,
                  output ready);
endinterface

// ----- rtl/core/psks_ram.sv -----
// ----------------------------------------------------------------------------
// psks_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module psks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/prioritized_sorted_key_substitution.sv -----
// ----------------------------------------------------------------------------
// prioritized_sorted_key_substitution: prioritized sorted key substitution
// Insert and clear act on the selected table, then present the result. Lookup
//   walks the tables in order, skipping unloaded or empty ones, with a binary
//   search of up to ceil(log2(n+1)) probes per table, 9 for 256 entries.
// Finish load insertion-sorts the table one entry at a time, then marks it
//   loaded. A bad table select on insert, finish or clear has no effect.
// One item in flight; a new request is accepted only in the idle state.
// Reset (rst_n low, synchronous) empties and unloads all tables.
// ----------------------------------------------------------------------------
module prioritized_sorted_key_substitution #(
  parameter int TABLE_DEPTH = 256,
  parameter int TABLE_COUNT = 3
) (
  input logic        clk,
  input logic        rst_n,
  psks_in_if.sink    in_chan,
  psks_out_if.source out_chan
);
  import psks_pkg::*;

  // Table storage spans all tables back to back; table t starts at t*TABLE_DEPTH.
  localparam int STORE_DEPTH = TABLE_COUNT * TABLE_DEPTH;
  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int TW  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int TCW = $clog2(TABLE_COUNT + 1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_EXEC     = 11'b000_0000_0010,
    S_SORT_RI  = 11'b000_0000_0100,
    S_SORT_LI  = 11'b000_0000_1000,
    S_SORT_RJ  = 11'b000_0001_0000,
    S_SORT_CJ  = 11'b000_0010_0000,
    S_SORT_WR  = 11'b000_0100_0000,
    S_LK_TBL   = 11'b000_1000_0000,
    S_LK_PROBE = 11'b001_0000_0000,
    S_LK_CMP   = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  // Control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r [TABLE_COUNT];
  logic [CW-1:0]    count_nxt [TABLE_COUNT];
  logic             loaded_r [TABLE_COUNT];
  logic             loaded_nxt [TABLE_COUNT];
  logic             out_valid_r, out_valid_nxt;

  // Working registers of the current item
  opcode_t          op_r, op_nxt;
  logic [TCW-1:0]   t_r, t_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] to_r, to_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    mid_r, mid_nxt;
  logic             hit_r, hit_nxt;
  logic [KEY_W-1:0] hit_to_r, hit_to_nxt;
  logic             res_found_r, res_found_nxt;
  logic [KEY_W-1:0] res_key_r, res_key_nxt;
  status_t          res_status_r, res_status_nxt;

  // Output register
  logic             out_found_r, out_found_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  status_t          out_status_r, out_status_nxt;

  // RAM ports
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [KEY_W-1:0] ram_wr_from;
  logic [KEY_W-1:0] ram_wr_to;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [KEY_W-1:0] rd_from;
  logic [KEY_W-1:0] rd_to;

  // Shared key comparator: stored key against the item's key
  logic             cmp_lt;
  logic             cmp_eq;

  logic [TW-1:0]    tix;
  logic [CW-1:0]    cur_count;
  logic             cur_loaded;
  logic [CW-1:0]    mid_calc;
  logic             sel_ok;

  psks_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_entry_from (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_from),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_from)
  );

  psks_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_entry_to (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_to),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_to)
  );

  assign cmp_lt = (rd_from < key_r);
  assign cmp_eq = (rd_from == key_r);

  // Per-table state is read at the one table index of the current item.
  assign tix        = t_r[TW-1:0];
  assign cur_count  = count_r[tix];
  assign cur_loaded = loaded_r[tix];

  // Midpoint of the open search window [lo, hi)
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);

  assign sel_ok = (32'(in_chan.table_sel) < 32'(TABLE_COUNT));

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.found      = out_found_r;
  assign out_chan.result_key = out_key_r;
  assign out_chan.status     = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    loaded_nxt     = loaded_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    t_nxt          = t_r;
    base_nxt       = base_r;
    key_nxt        = key_r;
    to_nxt         = to_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    hit_nxt        = hit_r;
    hit_to_nxt     = hit_to_r;
    res_found_nxt  = res_found_r;
    res_key_nxt    = res_key_r;
    res_status_nxt = res_status_r;
    out_found_nxt  = out_found_r;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = base_r;
    ram_wr_from = key_r;
    ram_wr_to   = to_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = base_r;

    // Drop the held result once the sink takes it.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt         = opcode_t'(in_chan.opcode);
          key_nxt        = in_chan.from_key;
          to_nxt         = in_chan.to_key;
          res_found_nxt  = 1'b0;
          res_key_nxt    = '0;
          res_status_nxt = ST_OK;
          if (opcode_t'(in_chan.opcode) == OP_LOOKUP) begin
            t_nxt     = '0;
            base_nxt  = '0;
            state_nxt = S_LK_TBL;
          end else if (sel_ok) begin
            t_nxt     = TCW'(in_chan.table_sel);
            base_nxt  = AW'(32'(in_chan.table_sel) * 32'(TABLE_DEPTH));
            state_nxt = S_EXEC;
          end else begin
            // Out-of-range table: no effect, all-zero result.
            state_nxt = S_DONE;
          end
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_INSERT: begin
            // A loaded table rejects first, then a full one.
            if (cur_loaded) begin
              res_status_nxt = ST_LOADED;
            end else if (cur_count == CW'(TABLE_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_wr_en       = 1'b1;
              ram_wr_addr     = base_r + AW'(cur_count);
              count_nxt[tix]  = cur_count + CW'(1);
            end
            state_nxt = S_DONE;
          end
          OP_FINISH: begin
            i_nxt     = CW'(1);
            state_nxt = S_SORT_RI;
          end
          OP_CLEAR: begin
            count_nxt[tix]  = '0;
            loaded_nxt[tix] = 1'b0;
            state_nxt       = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Stable insertion sort: take entry i, shift larger keys up by one.
      S_SORT_RI: begin
        if (i_r >= cur_count) begin
          loaded_nxt[tix] = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = base_r + AW'(i_r);
          state_nxt   = S_SORT_LI;
        end
      end

      S_SORT_LI: begin
        key_nxt   = rd_from;
        to_nxt    = rd_to;
        j_nxt     = i_r;
        state_nxt = S_SORT_RJ;
      end

      S_SORT_RJ: begin
        if (j_r == '0) begin
          state_nxt = S_SORT_WR;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = base_r + AW'(j_r - CW'(1));
          state_nxt   = S_SORT_CJ;
        end
      end

      S_SORT_CJ: begin
        // Strictly greater moves up; equal keys stay ahead, keeping insert order.
        if (!cmp_lt && !cmp_eq) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = base_r + AW'(j_r);
          ram_wr_from = rd_from;
          ram_wr_to   = rd_to;
          j_nxt       = j_r - CW'(1);
          state_nxt   = S_SORT_RJ;
        end else begin
          state_nxt = S_SORT_WR;
        end
      end

      S_SORT_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = base_r + AW'(j_r);
        i_nxt       = i_r + CW'(1);
        state_nxt   = S_SORT_RI;
      end

      // Walk the tables in priority order; skip unloaded or empty ones.
      S_LK_TBL: begin
        if (t_r == TCW'(TABLE_COUNT)) begin
          res_found_nxt = 1'b0;
          res_key_nxt   = key_r;
          state_nxt     = S_DONE;
        end else if (!cur_loaded || (cur_count == '0)) begin
          t_nxt    = t_r + TCW'(1);
          base_nxt = base_r + AW'(TABLE_DEPTH);
        end else begin
          lo_nxt    = '0;
          hi_nxt    = cur_count;
          hit_nxt   = 1'b0;
          state_nxt = S_LK_PROBE;
        end
      end

      // Lower-bound search; the last probe that lowered hi is the bound.
      S_LK_PROBE: begin
        if (lo_r < hi_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = base_r + AW'(mid_calc);
          mid_nxt     = mid_calc;
          state_nxt   = S_LK_CMP;
        end else if (hit_r) begin
          res_found_nxt = 1'b1;
          res_key_nxt   = hit_to_r;
          state_nxt     = S_DONE;
        end else begin
          t_nxt     = t_r + TCW'(1);
          base_nxt  = base_r + AW'(TABLE_DEPTH);
          state_nxt = S_LK_TBL;
        end
      end

      S_LK_CMP: begin
        if (cmp_lt) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt     = mid_r;
          hit_nxt    = cmp_eq;
          hit_to_nxt = rd_to;
        end
        state_nxt = S_LK_PROBE;
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_key_nxt    = res_key_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int t = 0; t < TABLE_COUNT; t++) begin
        count_r[t]  <= '0;
        loaded_r[t] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      loaded_r    <= loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    t_r          <= t_nxt;
    base_r       <= base_nxt;
    key_r        <= key_nxt;
    to_r         <= to_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    hit_r        <= hit_nxt;
    hit_to_r     <= hit_to_nxt;
    res_found_r  <= res_found_nxt;
    res_key_r    <= res_key_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
